### rtl/zonal_group_statistics_defines.svh
// assertion macros for the zonal group statistics block
`ifndef ZONAL_GROUP_STATISTICS_DEFINES_SVH
`define ZONAL_GROUP_STATISTICS_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ZGS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ZGS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/zgs_pkg.sv
// types and constants shared by the zonal group statistics modules
package zgs_pkg;

   localparam int RESULT_LIMIT = 64;
   localparam logic [62:0] SQ_MAX = {63{1'b1}};
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
   localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] SUM_MIN = {1'b1, {63{1'b0}}};

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_DRAIN  = 1'b1;

   localparam logic CFG_CATEGORIES = 1'b0;
   localparam logic CFG_GRIDS      = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [15:0]        zone_id;
      logic [15:0]        category_a;
      logic [15:0]        category_b;
      logic signed [23:0] value_a;
      logic               value_a_valid;
      logic signed [23:0] value_b;
      logic               value_b_valid;
   } req_type;

   typedef struct packed {
      logic [5:0]         group_number;
      logic [15:0]        group_zone;
      logic [15:0]        group_category_a;
      logic [15:0]        group_category_b;
      logic [31:0]        cell_count;
      logic               grid_number;
      logic [31:0]        valid_count;
      logic signed [23:0] min_value;
      logic signed [23:0] max_value;
      logic signed [63:0] value_sum;
      logic [62:0]        square_sum;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        count;
      logic signed [23:0] min_value;
      logic signed [23:0] max_value;
      logic signed [63:0] sum;
      logic [62:0]        square;
   } stat_type;

   typedef struct packed {
      logic               wr;
      logic               fresh;
      logic               apply;
      logic signed [23:0] value;
      logic [47:0]        square;
   } stat_cmd_type;

endpackage

### rtl/zgs_key_table.sv
// group key and cell count memory with key compare on the read port
module zgs_key_table #(
   parameter int MAX_GROUPS = 32,
   parameter int KEY_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_GROUPS)-1:0] rd_addr,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_GROUPS)-1:0] wr_addr,
   input  logic [3*KEY_BITS-1:0]         wr_key,
   input  logic [31:0]                   wr_cells,
   input  logic [3*KEY_BITS-1:0]         probe_key,
   output logic [3*KEY_BITS-1:0]         rd_key,
   output logic [31:0]                   rd_cells,
   output logic                          match
);

   localparam int WORD_BITS = 3 * KEY_BITS + 32;

   logic [WORD_BITS-1:0] mem [MAX_GROUPS];
   logic [WORD_BITS-1:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= {wr_key, wr_cells};
      end
   end

   assign rd_key   = rd_word_ff[WORD_BITS-1:32];
   assign rd_cells = rd_word_ff[31:0];
   assign match    = (rd_key == probe_key);

endmodule

### rtl/zgs_stat_table.sv
// per group and grid statistics memory with read-modify-write update
module zgs_stat_table #(
   parameter int ADDR_BITS = 6
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  zgs_pkg::stat_cmd_type cmd,
   output zgs_pkg::stat_type    rd_stat
);

   zgs_pkg::stat_type mem [2**ADDR_BITS];
   zgs_pkg::stat_type rd_stat_ff;
   zgs_pkg::stat_type old_stat;
   zgs_pkg::stat_type new_stat;
   zgs_pkg::stat_type next_stat;
   logic signed [63:0] value_ext;
   logic signed [63:0] sum_raw;
   logic [63:0]        square_raw;
   logic               first;
   logic               sum_ovf;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_stat_ff <= mem[rd_addr];
      end
      if (cmd.wr) begin
         mem[wr_addr] <= next_stat;
      end
   end

   always_comb begin
      old_stat   = cmd.fresh ? '0 : rd_stat_ff;
      first      = (old_stat.count == 32'd0);
      value_ext  = 64'(cmd.value);
      sum_raw    = old_stat.sum + value_ext;
      sum_ovf    = (old_stat.sum[63] == value_ext[63]) && (sum_raw[63] != old_stat.sum[63]);
      square_raw = {1'b0, old_stat.square} + {16'd0, cmd.square};
      new_stat.count = (old_stat.count == zgs_pkg::COUNT_MAX) ? old_stat.count
                                                              : old_stat.count + 32'd1;
      new_stat.min_value = (first || cmd.value < old_stat.min_value) ? cmd.value
                                                                     : old_stat.min_value;
      new_stat.max_value = (first || cmd.value > old_stat.max_value) ? cmd.value
                                                                     : old_stat.max_value;
      if (sum_ovf) begin
         new_stat.sum = old_stat.sum[63] ? zgs_pkg::SUM_MIN : zgs_pkg::SUM_MAX;
      end else begin
         new_stat.sum = sum_raw;
      end
      new_stat.square = square_raw[63] ? zgs_pkg::SQ_MAX : square_raw[62:0];
      next_stat = cmd.apply ? new_stat : old_stat;
   end

   assign rd_stat = rd_stat_ff;

endmodule

### rtl/zonal_group_statistics.sv
// top level: group-by aggregation engine for zonal statistics
// sample: after accept, the key memory is scanned entry by entry up to a match or fill;
//   a new key or a full table adds a create step, then a grid read and a grid write
//   follow per active data grid on a hit, per grid kept in memory on a new key
// drain: after accept, per result a read of both memories, then a load held by rsp_stall
// reset zeroes fill count, categories and output valid, sets grids to 1; memories stay
module zonal_group_statistics #(
   parameter int MAX_GROUPS  = 32,
   parameter int VALUE_GRIDS = 2,
   parameter int KEY_BITS    = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  zgs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output zgs_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic             csr_index,
   input  logic [1:0]       csr_data
);

   `include "zonal_group_statistics_defines.svh"

   localparam int IB = $clog2(MAX_GROUPS);
   localparam int GB = (VALUE_GRIDS > 1) ? $clog2(VALUE_GRIDS) : 1;
   localparam int NG_MAX = (VALUE_GRIDS < 2) ? VALUE_GRIDS : 2;
   localparam int KW = 3 * KEY_BITS;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_SCAN    = 7'b0000010,
      ST_CREATE  = 7'b0000100,
      ST_GRID_RD = 7'b0001000,
      ST_GRID_WR = 7'b0010000,
      ST_DR_RD   = 7'b0100000,
      ST_DR_LD   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] cat_ff, cat_in;
   logic [1:0] grids_ff, grids_in;
   logic [IB:0] fill_ff, fill_in;
   logic [IB-1:0] idx_ff, idx_in;
   logic [IB-1:0] hit_ff, hit_in;
   logic g_ff, g_in;
   logic [1:0] lim_ff, lim_in;
   logic fresh_ff, fresh_in;
   logic [5:0] n_ff, n_in;
   logic zero_ff, zero_in;
   logic [KW-1:0] key_ff, key_in;
   zgs_pkg::req_type req_ff, req_in;
   logic [47:0] sq_a_ff, sq_a_in, sq_b_ff, sq_b_in;
   logic rsp_valid_ff, rsp_valid_in;
   zgs_pkg::rsp_type rsp_ff, rsp_in;

   logic [1:0] grids_lim, ng, per;
   logic accept, load, final_rsp;
   logic signed [47:0] prod_a, prod_b;
   logic key_rd_en, key_wr_en, key_match;
   logic [IB-1:0] key_rd_addr, key_wr_addr;
   logic [KW-1:0] key_wr, rd_key;
   logic [31:0] cells_wr, rd_cells;
   logic stat_rd_en;
   logic [IB+GB-1:0] stat_rd_addr, stat_wr_addr;
   zgs_pkg::stat_cmd_type stat_cmd;
   zgs_pkg::stat_type rd_stat;

   assign grids_lim = (grids_ff == 2'd3) ? 2'd2 : grids_ff;
   assign ng = (grids_lim > 2'(NG_MAX)) ? 2'(NG_MAX) : grids_lim;
   assign per = (ng == 2'd0) ? 2'd1 : ng;
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign load = (state_ff == ST_DR_LD) && (!rsp_valid_ff || !rsp_stall);
   assign final_rsp = (({1'b0, idx_ff} + (IB + 1)'(1)) == fill_ff)
                      && ({1'b0, g_ff} == per - 2'd1)
                      || (n_ff == 6'(zgs_pkg::RESULT_LIMIT - 1));
   assign prod_a = req_data.value_a * req_data.value_a;
   assign prod_b = req_data.value_b * req_data.value_b;

   zgs_key_table #(.MAX_GROUPS(MAX_GROUPS), .KEY_BITS(KEY_BITS)) u_keys (
      .clock     (clock),
      .rd_en     (key_rd_en),
      .rd_addr   (key_rd_addr),
      .wr_en     (key_wr_en),
      .wr_addr   (key_wr_addr),
      .wr_key    (key_wr),
      .wr_cells  (cells_wr),
      .probe_key (key_ff),
      .rd_key    (rd_key),
      .rd_cells  (rd_cells),
      .match     (key_match)
   );

   zgs_stat_table #(.ADDR_BITS(IB + GB)) u_stats (
      .clock   (clock),
      .rd_en   (stat_rd_en),
      .rd_addr (stat_rd_addr),
      .wr_addr (stat_wr_addr),
      .cmd     (stat_cmd),
      .rd_stat (rd_stat)
   );

   always_comb begin
      state_in = state_ff;
      cat_in = cat_ff;
      grids_in = grids_ff;
      fill_in = fill_ff;
      idx_in = idx_ff;
      hit_in = hit_ff;
      g_in = g_ff;
      lim_in = lim_ff;
      fresh_in = fresh_ff;
      n_in = n_ff;
      zero_in = zero_ff;
      key_in = key_ff;
      req_in = req_ff;
      sq_a_in = sq_a_ff;
      sq_b_in = sq_b_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      key_rd_en = 1'b0;
      key_rd_addr = idx_ff;
      key_wr_en = 1'b0;
      key_wr_addr = idx_ff;
      key_wr = key_ff;
      cells_wr = (rd_cells == zgs_pkg::COUNT_MAX) ? rd_cells : rd_cells + 32'd1;
      stat_rd_en = 1'b0;
      stat_rd_addr = {hit_ff, GB'(g_ff)};
      stat_wr_addr = {hit_ff, GB'(g_ff)};
      stat_cmd.wr = 1'b0;
      stat_cmd.fresh = fresh_ff;
      stat_cmd.apply = 1'b0;
      stat_cmd.value = g_ff ? req_ff.value_b : req_ff.value_a;
      stat_cmd.square = g_ff ? sq_b_ff : sq_a_ff;

      if (csr_write_en) begin
         case (csr_index)
            zgs_pkg::CFG_CATEGORIES: cat_in = csr_data;
            zgs_pkg::CFG_GRIDS:      grids_in = csr_data;
            default:                 cat_in = cat_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               sq_a_in = 48'(prod_a);
               sq_b_in = 48'(prod_b);
               key_in = {KEY_BITS'(req_data.zone_id),
                         (cat_ff != 2'd0) ? KEY_BITS'(req_data.category_a) : KEY_BITS'(0),
                         (cat_ff[1]) ? KEY_BITS'(req_data.category_b) : KEY_BITS'(0)};
               idx_in = '0;
               g_in = 1'b0;
               n_in = '0;
               zero_in = (ng == 2'd0);
               if (req_data.kind == zgs_pkg::KIND_DRAIN) begin
                  if (fill_ff != '0) begin
                     state_in = ST_DR_RD;
                  end
               end else if (fill_ff == '0) begin
                  state_in = ST_CREATE;
               end else begin
                  key_rd_en = 1'b1;
                  key_rd_addr = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (key_match) begin
               key_wr_en = 1'b1;
               hit_in = idx_ff;
               fresh_in = 1'b0;
               lim_in = ng;
               state_in = (ng == 2'd0) ? ST_IDLE : ST_GRID_RD;
            end else if (({1'b0, idx_ff} + (IB + 1)'(1)) == fill_ff) begin
               state_in = ST_CREATE;
            end else begin
               idx_in = idx_ff + IB'(1);
               key_rd_en = 1'b1;
               key_rd_addr = idx_ff + IB'(1);
            end
         end
         ST_CREATE: begin
            if (fill_ff == (IB + 1)'(MAX_GROUPS)) begin
               state_in = ST_IDLE;
            end else begin
               key_wr_en = 1'b1;
               key_wr_addr = fill_ff[IB-1:0];
               cells_wr = 32'd1;
               hit_in = fill_ff[IB-1:0];
               fill_in = fill_ff + (IB + 1)'(1);
               fresh_in = 1'b1;
               lim_in = 2'(NG_MAX);
               state_in = ST_GRID_RD;
            end
         end
         ST_GRID_RD: begin
            stat_rd_en = 1'b1;
            state_in = ST_GRID_WR;
         end
         ST_GRID_WR: begin
            stat_cmd.wr = 1'b1;
            stat_cmd.apply = ({1'b0, g_ff} < ng)
                             && (g_ff ? req_ff.value_b_valid : req_ff.value_a_valid);
            if ({1'b0, g_ff} == lim_ff - 2'd1) begin
               state_in = ST_IDLE;
            end else begin
               g_in = 1'b1;
               state_in = ST_GRID_RD;
            end
         end
         ST_DR_RD: begin
            key_rd_en = 1'b1;
            stat_rd_en = 1'b1;
            stat_rd_addr = {idx_ff, GB'(g_ff)};
            state_in = ST_DR_LD;
         end
         ST_DR_LD: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_in.group_number = 6'({1'b0, idx_ff} + (IB + 1)'(1));
               rsp_in.group_zone = 16'(rd_key[KW-1 -: KEY_BITS]);
               rsp_in.group_category_a = 16'(rd_key[2*KEY_BITS-1 -: KEY_BITS]);
               rsp_in.group_category_b = 16'(rd_key[KEY_BITS-1:0]);
               rsp_in.cell_count = rd_cells;
               rsp_in.grid_number = g_ff;
               rsp_in.valid_count = zero_ff ? '0 : rd_stat.count;
               rsp_in.min_value = zero_ff ? '0 : rd_stat.min_value;
               rsp_in.max_value = zero_ff ? '0 : rd_stat.max_value;
               rsp_in.value_sum = zero_ff ? '0 : rd_stat.sum;
               rsp_in.square_sum = zero_ff ? '0 : rd_stat.square;
               rsp_in.last = final_rsp;
               n_in = n_ff + 6'd1;
               if (final_rsp) begin
                  fill_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  if ({1'b0, g_ff} == per - 2'd1) begin
                     g_in = 1'b0;
                     idx_in = idx_ff + IB'(1);
                  end else begin
                     g_in = 1'b1;
                  end
                  state_in = ST_DR_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cat_ff <= 2'd0;
         grids_ff <= 2'd1;
         fill_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cat_ff <= cat_in;
         grids_ff <= grids_in;
         fill_ff <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      hit_ff <= hit_in;
      g_ff <= g_in;
      lim_ff <= lim_in;
      fresh_ff <= fresh_in;
      n_ff <= n_in;
      zero_ff <= zero_in;
      key_ff <= key_in;
      req_ff <= req_in;
      sq_a_ff <= sq_a_in;
      sq_b_ff <= sq_b_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `ZGS_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= (IB + 1)'(MAX_GROUPS), "fill above table size")
   `ZGS_ASSERT_NOW(a_scan_in_range, state_ff == ST_SCAN, {1'b0, idx_ff} < fill_ff, "scan past fill")
   `ZGS_ASSERT_NEXT(a_drain_clears, load && final_rsp, fill_ff == '0 && rsp_data.last, "drain end")
   `ZGS_ASSERT_NOW(a_grid_limit, state_ff == ST_GRID_WR, {1'b0, g_ff} < lim_ff, "grid overrun")

endmodule
